// ===== hdl/sdf_pkg.sv =====
// shared constants, codes and types of the signed decimal formatter
package sdf_pkg;

    localparam int VALUE_W    = 32;
    localparam int CHAR_W     = 8;
    localparam int CNT_W      = 7;
    localparam int FIELD_W    = 6;
    localparam int BIT_CNT_W  = $clog2(VALUE_W);
    localparam int BCD_DIGITS = 10;
    localparam int BCD_W      = 4 * BCD_DIGITS;
    localparam int ND_W       = $clog2(BCD_DIGITS + 1);

    localparam int DIGIT_SLOTS_DEF = 10;
    localparam int MAX_FIELD       = 63;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = FIELD_W;

    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH_GIVEN     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FIELD_WIDTH     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PRECISION_GIVEN = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DIGIT_PRECISION = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_LEFT_JUSTIFY    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_ZERO_PAD        = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_FORCE_ZERO_FILL = 3'd6;

    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2d;

    typedef struct packed {
        logic               width_given;
        logic [FIELD_W-1:0] field_width;
        logic               precision_given;
        logic [FIELD_W-1:0] digit_precision;
        logic               left_justify;
        logic               zero_pad;
        logic               force_zero_fill;
    } cfg_t;

    typedef struct packed {
        logic            done;
        logic [ND_W-1:0] nd;
        logic [3:0]      top_digit;
    } conv_t;

    typedef struct packed {
        logic [CNT_W-1:0] lead_end;
        logic [CNT_W-1:0] sign_end;
        logic [CNT_W-1:0] zero_end;
        logic [CNT_W-1:0] digit_end;
        logic [CNT_W-1:0] total;
        logic             suppress;
    } plan_t;

endpackage

// ===== hdl/sdf_bin2bcd.sv =====
// bit-serial binary to bcd conversion and leading digit trimming
module sdf_bin2bcd #(
    parameter int DIGIT_SLOTS = sdf_pkg::DIGIT_SLOTS_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         start,
    input  logic [sdf_pkg::VALUE_W-1:0]  magnitude,
    input  logic                         shift_digit,
    output sdf_pkg::conv_t               status
);
    import sdf_pkg::*;

    localparam int SLOT_LIM = (DIGIT_SLOTS < BCD_DIGITS) ? DIGIT_SLOTS : BCD_DIGITS;
    localparam logic [ND_W-1:0]      SLOT_CAP = ND_W'(SLOT_LIM);
    localparam logic [ND_W-1:0]      ND_FULL  = ND_W'(BCD_DIGITS);
    localparam logic [ND_W-1:0]      ND_ONE   = ND_W'(1);
    localparam logic [BIT_CNT_W-1:0] BIT_LAST = BIT_CNT_W'(VALUE_W - 1);

    localparam logic [1:0] CV_IDLE  = 2'd0;
    localparam logic [1:0] CV_SHIFT = 2'd1;
    localparam logic [1:0] CV_NORM  = 2'd2;

    logic [1:0]           phase_reg, phase_next;
    logic                 done_reg, done_next;
    logic [BIT_CNT_W-1:0] cnt_reg, cnt_next;
    logic [VALUE_W-1:0]   mag_reg, mag_next;
    logic [BCD_W-1:0]     bcd_reg, bcd_next;
    logic [BCD_W-1:0]     adjusted;
    logic [ND_W-1:0]      nd_reg, nd_next;
    logic                 seen_reg, seen_next;
    logic [3:0]           top;

    assign top = bcd_reg[BCD_W-1 -: 4];

    // add 3 to every digit of 5 or more before the doubling shift
    always_comb begin
        for (int i = 0; i < BCD_DIGITS; i++) begin
            adjusted[4*i +: 4] = (bcd_reg[4*i +: 4] >= 4'd5) ?
                                 bcd_reg[4*i +: 4] + 4'd3 : bcd_reg[4*i +: 4];
        end
    end

    always_comb begin
        phase_next = phase_reg;
        done_next  = 1'b0;
        cnt_next   = cnt_reg;
        mag_next   = mag_reg;
        bcd_next   = bcd_reg;
        nd_next    = nd_reg;
        seen_next  = seen_reg;
        unique case (phase_reg)
            CV_IDLE: begin
                if (start) begin
                    mag_next   = magnitude;
                    bcd_next   = '0;
                    cnt_next   = '0;
                    phase_next = CV_SHIFT;
                end else if (shift_digit) begin
                    bcd_next = {bcd_reg[BCD_W-5:0], 4'd0};
                end
            end
            CV_SHIFT: begin
                bcd_next = {adjusted[BCD_W-2:0], mag_reg[VALUE_W-1]};
                mag_next = {mag_reg[VALUE_W-2:0], 1'b0};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == BIT_LAST) begin
                    nd_next    = ND_FULL;
                    seen_next  = 1'b0;
                    phase_next = CV_NORM;
                end
            end
            CV_NORM: begin
                // strip leading zeros, then drop digits beyond the slot count
                if (!seen_reg && nd_reg > ND_ONE && top == 4'd0) begin
                    bcd_next = {bcd_reg[BCD_W-5:0], 4'd0};
                    nd_next  = nd_reg - 1'b1;
                end else if (nd_reg > SLOT_CAP) begin
                    bcd_next  = {bcd_reg[BCD_W-5:0], 4'd0};
                    nd_next   = nd_reg - 1'b1;
                    seen_next = 1'b1;
                end else begin
                    done_next  = 1'b1;
                    phase_next = CV_IDLE;
                end
            end
            default: begin
                phase_next = CV_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= CV_IDLE;
            done_reg  <= 1'b0;
        end else begin
            phase_reg <= phase_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        cnt_reg  <= cnt_next;
        mag_reg  <= mag_next;
        bcd_reg  <= bcd_next;
        nd_reg   <= nd_next;
        seen_reg <= seen_next;
    end

    assign status.done      = done_reg;
    assign status.nd        = nd_reg;
    assign status.top_digit = top;

endmodule

// ===== hdl/sdf_planner.sv =====
// padding arithmetic: segment boundaries of the character stream
module sdf_planner (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      start,
    input  sdf_pkg::cfg_t             cfg,
    input  logic                      neg,
    input  logic                      mag_zero,
    input  logic [sdf_pkg::ND_W-1:0]  nd,
    output sdf_pkg::plan_t            plan,
    output logic                      done
);
    import sdf_pkg::*;

    localparam int CAP_LIM = (MAX_FIELD < 63) ? MAX_FIELD : 63;
    localparam logic [FIELD_W-1:0] FIELD_CAP = FIELD_W'(CAP_LIM);

    localparam logic [1:0] PL_IDLE = 2'd0;
    localparam logic [1:0] PL_LEN  = 2'd1;
    localparam logic [1:0] PL_PAD  = 2'd2;
    localparam logic [1:0] PL_MARK = 2'd3;

    logic [1:0]       phase_reg, phase_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] zeros_reg, zeros_next;
    logic [CNT_W-1:0] len_reg, len_next;
    logic [CNT_W-1:0] spaces_reg, spaces_next;
    logic [CNT_W-1:0] dpart_reg, dpart_next;
    logic             suppress_reg, suppress_next;
    plan_t            plan_reg, plan_next;

    logic [CNT_W-1:0] w, p, nd_ext, neg_ext, len0, z1, len1, lead;

    assign w       = {1'b0, (cfg.field_width > FIELD_CAP) ? FIELD_CAP : cfg.field_width};
    assign p       = {1'b0, (cfg.digit_precision > FIELD_CAP) ? FIELD_CAP
                                                             : cfg.digit_precision};
    assign nd_ext  = CNT_W'(nd);
    assign neg_ext = {{(CNT_W-1){1'b0}}, neg};
    assign len0    = neg_ext + nd_ext;
    assign z1      = (cfg.precision_given && p > nd_ext) ? p - nd_ext : '0;
    assign len1    = len0 + z1;
    assign lead    = cfg.left_justify ? '0 : spaces_reg;

    always_comb begin
        phase_next    = phase_reg;
        done_next     = 1'b0;
        zeros_next    = zeros_reg;
        len_next      = len_reg;
        spaces_next   = spaces_reg;
        dpart_next    = dpart_reg;
        suppress_next = suppress_reg;
        plan_next     = plan_reg;
        unique case (phase_reg)
            PL_IDLE: begin
                if (start) begin
                    phase_next = PL_LEN;
                end
            end
            PL_LEN: begin
                if (cfg.force_zero_fill && cfg.zero_pad && w > len0) begin
                    zeros_next = w - len0;
                    len_next   = w;
                end else if (cfg.width_given && cfg.zero_pad && !cfg.precision_given
                             && !cfg.left_justify && w > len1) begin
                    zeros_next = z1 + (w - len1);
                    len_next   = w;
                end else begin
                    zeros_next = z1;
                    len_next   = len1;
                end
                phase_next = PL_PAD;
            end
            PL_PAD: begin
                if (cfg.width_given && w > len_reg &&
                    (!cfg.zero_pad || cfg.left_justify || cfg.precision_given)) begin
                    spaces_next = w - len_reg;
                end else begin
                    spaces_next = '0;
                end
                // zero with precision zero: the digit gives way to one space or nothing
                suppress_next = mag_zero && cfg.precision_given && p == '0;
                if (suppress_next) begin
                    dpart_next = {{(CNT_W-1){1'b0}}, cfg.width_given && w != '0};
                end else begin
                    dpart_next = nd_ext;
                end
                phase_next = PL_MARK;
            end
            PL_MARK: begin
                plan_next.lead_end  = lead;
                plan_next.sign_end  = lead + neg_ext;
                plan_next.zero_end  = plan_next.sign_end + zeros_reg;
                plan_next.digit_end = plan_next.zero_end + dpart_reg;
                plan_next.total     = plan_next.digit_end +
                                      (cfg.left_justify ? spaces_reg : '0);
                plan_next.suppress  = suppress_reg;
                done_next           = 1'b1;
                phase_next          = PL_IDLE;
            end
            default: begin
                phase_next = PL_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PL_IDLE;
            done_reg  <= 1'b0;
        end else begin
            phase_reg <= phase_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        zeros_reg    <= zeros_next;
        len_reg      <= len_next;
        spaces_reg   <= spaces_next;
        dpart_reg    <= dpart_next;
        suppress_reg <= suppress_next;
        plan_reg     <= plan_next;
    end

    assign plan = plan_reg;
    assign done = done_reg;

endmodule

// ===== hdl/sdf_emitter.sv =====
// character sequencer and output register of the result channel
module sdf_emitter (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         start,
    input  sdf_pkg::plan_t               plan,
    input  logic [3:0]                   top_digit,
    output logic                         shift_digit,
    output logic                         done,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [sdf_pkg::CHAR_W-1:0]   m_out_char,
    output logic                         m_last_char,
    output logic [sdf_pkg::CNT_W-1:0]    m_total_count
);
    import sdf_pkg::*;

    logic             active_reg, active_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] idx_reg, idx_next;
    logic             valid_reg, valid_next;
    logic [CHAR_W-1:0] char_reg, char_next;
    logic             last_reg, last_next;
    logic [CNT_W-1:0] count_reg, count_next;

    logic              load;
    logic              is_last;
    logic              is_digit;
    logic [CHAR_W-1:0] ch;

    assign load    = active_reg && (!valid_reg || m_ready);
    assign is_last = (idx_reg + 1'b1) == plan.total;

    always_comb begin
        is_digit = 1'b0;
        priority if (idx_reg < plan.lead_end) begin
            ch = CH_SPACE;
        end else if (idx_reg < plan.sign_end) begin
            ch = CH_MINUS;
        end else if (idx_reg < plan.zero_end) begin
            ch = CH_ZERO;
        end else if (idx_reg < plan.digit_end) begin
            if (plan.suppress) begin
                ch = CH_SPACE;
            end else begin
                ch       = CH_ZERO + {4'd0, top_digit};
                is_digit = 1'b1;
            end
        end else begin
            ch = CH_SPACE;
        end
    end

    always_comb begin
        active_next = active_reg;
        done_next   = 1'b0;
        idx_next    = idx_reg;
        valid_next  = valid_reg && !m_ready;
        char_next   = char_reg;
        last_next   = last_reg;
        count_next  = count_reg;
        if (start) begin
            idx_next = '0;
            // nothing to print: finish without a transfer
            if (plan.total == '0) begin
                done_next = 1'b1;
            end else begin
                active_next = 1'b1;
            end
        end else if (load) begin
            valid_next = 1'b1;
            char_next  = ch;
            last_next  = is_last;
            count_next = is_last ? plan.total : '0;
            idx_next   = idx_reg + 1'b1;
            if (is_last) begin
                active_next = 1'b0;
                done_next   = 1'b1;
            end
        end
    end

    assign shift_digit = load && is_digit && !start;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg <= 1'b0;
            done_reg   <= 1'b0;
            valid_reg  <= 1'b0;
        end else begin
            active_reg <= active_next;
            done_reg   <= done_next;
            valid_reg  <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg   <= idx_next;
        char_reg  <= char_next;
        last_reg  <= last_next;
        count_reg <= count_next;
    end

    assign done          = done_reg;
    assign m_valid       = valid_reg;
    assign m_out_char    = char_reg;
    assign m_last_char   = last_reg;
    assign m_total_count = count_reg;

endmodule

// ===== hdl/signed_decimal_formatter.sv =====
// Formats one signed 32-bit value as printf %d text, one ASCII character per
// output transfer, the last one flagged and carrying the character count.
// One value is handled at a time: after an input transfer the magnitude goes
// through a bit-serial binary to bcd converter (one bit per cycle), leading
// zero digits are trimmed one per cycle and digits beyond the slot count
// dropped, the padding is worked out in length, padding and mark steps, and
// then characters leave at one per cycle while the output is ready. The next
// value is taken once the last character has been loaded into the output
// register. Configuration writes take effect at once and belong in idle time.
module signed_decimal_formatter #(
    parameter int DIGIT_SLOTS = sdf_pkg::DIGIT_SLOTS_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic signed [sdf_pkg::VALUE_W-1:0] s_value,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [sdf_pkg::CHAR_W-1:0]         m_out_char,
    output logic                               m_last_char,
    output logic [sdf_pkg::CNT_W-1:0]          m_total_count,
    input  logic                               cfg_we,
    input  logic [sdf_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [sdf_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import sdf_pkg::*;

    cfg_t               cfg_reg, cfg_next;
    logic               busy_reg, busy_next;
    logic               neg_reg, neg_next;
    logic               zero_reg, zero_next;
    logic               in_xfer;
    logic [VALUE_W-1:0] magnitude;
    conv_t              conv;
    plan_t              plan;
    logic               plan_done;
    logic               shift_digit;
    logic               emit_done;

    assign s_ready   = !busy_reg;
    assign in_xfer   = s_valid && s_ready;
    assign magnitude = s_value[VALUE_W-1] ? VALUE_W'(-s_value) : VALUE_W'(s_value);

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            unique case (cfg_index)
                CFG_WIDTH_GIVEN:     cfg_next.width_given     = cfg_data[0];
                CFG_FIELD_WIDTH:     cfg_next.field_width     = cfg_data[FIELD_W-1:0];
                CFG_PRECISION_GIVEN: cfg_next.precision_given = cfg_data[0];
                CFG_DIGIT_PRECISION: cfg_next.digit_precision = cfg_data[FIELD_W-1:0];
                CFG_LEFT_JUSTIFY:    cfg_next.left_justify    = cfg_data[0];
                CFG_ZERO_PAD:        cfg_next.zero_pad        = cfg_data[0];
                CFG_FORCE_ZERO_FILL: cfg_next.force_zero_fill = cfg_data[0];
                default:             cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb begin
        busy_next = busy_reg;
        neg_next  = neg_reg;
        zero_next = zero_reg;
        if (in_xfer) begin
            busy_next = 1'b1;
            neg_next  = s_value[VALUE_W-1];
            zero_next = s_value == '0;
        end else if (emit_done) begin
            busy_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg  <= '0;
            busy_reg <= 1'b0;
        end else begin
            cfg_reg  <= cfg_next;
            busy_reg <= busy_next;
        end
    end

    always_ff @(posedge aclk) begin
        neg_reg  <= neg_next;
        zero_reg <= zero_next;
    end

    sdf_bin2bcd #(
        .DIGIT_SLOTS (DIGIT_SLOTS)
    ) u_bin2bcd (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .start       (in_xfer),
        .magnitude   (magnitude),
        .shift_digit (shift_digit),
        .status      (conv)
    );

    sdf_planner u_planner (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (conv.done),
        .cfg      (cfg_reg),
        .neg      (neg_reg),
        .mag_zero (zero_reg),
        .nd       (conv.nd),
        .plan     (plan),
        .done     (plan_done)
    );

    sdf_emitter u_emitter (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .start            (plan_done),
        .plan             (plan),
        .top_digit        (conv.top_digit),
        .shift_digit      (shift_digit),
        .done             (emit_done),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_out_char       (m_out_char),
        .m_last_char      (m_last_char),
        .m_total_count    (m_total_count)
    );

endmodule
